FILE: rtl/core/bue_pkg.sv
`timescale 1ns / 1ps

package bue_pkg;

    // Format decision for the current document.
    typedef enum logic [1:0] {
        MODE_UNDECIDED = 2'd0,
        MODE_UTF8      = 2'd1,
        MODE_UTF16     = 2'd2
    } t_mode;

    localparam int CP_W = 21;

    localparam logic [7:0]  BOM8_0      = 8'hEF;
    localparam logic [7:0]  BOM8_1      = 8'hBB;
    localparam logic [7:0]  BOM8_2      = 8'hBF;
    localparam logic [7:0]  BOM16_0     = 8'hFF;
    localparam logic [7:0]  BOM16_1     = 8'hFE;
    localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
    localparam logic [7:0]  CH_QUOTE    = 8'h22;
    localparam logic [7:0]  CH_BSLASH   = 8'h5C;
    localparam logic [7:0]  CH_U        = 8'h75;
    localparam logic [7:0]  CH_ZERO     = 8'h30;
    localparam logic [7:0]  CH_SPACE    = 8'h20;

    // Work left by one accepted byte: up to two code points, or one raw byte
    // in UTF-8 mode, plus the end-of-document flag.
    typedef struct packed {
        logic            raw;
        logic [1:0]      ncp;
        logic [CP_W-1:0] cp0;
        logic [CP_W-1:0] cp1;
        logic            fin;
    } t_item;

    // Index of the last UTF-8 byte of a code point (raw bytes are single).
    function automatic logic [1:0] utf8_last(input logic [CP_W-1:0] cp, input logic raw);
        logic [1:0] r;
        if (raw || cp <= 21'h7F) begin
            r = 2'd0;
        end else if (cp <= 21'h7FF) begin
            r = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] last,
                                             input logic [1:0] idx);
        logic [7:0] r;
        r = cp[7:0];
        unique case (last)
            2'd0: r = cp[7:0];
            2'd1: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2: begin
                unique case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0: r = {5'b11110, cp[20:18]};
                    2'd1: r = {2'b10, cp[17:12]};
                    2'd2: r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h61 + {4'd0, v} - 8'd10);
    endfunction

    // Index of the last byte that the escape pass makes of one byte.
    function automatic logic [2:0] esc_last(input logic [7:0] c, input logic in_str);
        logic [2:0] r;
        r = 3'd0;
        if (in_str) begin
            if (c == CH_BSLASH) begin
                r = 3'd1;
            end else if (c < CH_SPACE) begin
                r = 3'd5;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] esc_byte(input logic [7:0] c, input logic in_str,
                                            input logic [2:0] idx);
        logic [7:0] r;
        r = c;
        if (in_str && c == CH_BSLASH) begin
            r = CH_BSLASH;
        end else if (in_str && c < CH_SPACE) begin
            unique case (idx)
                3'd0:    r = CH_BSLASH;
                3'd1:    r = CH_U;
                3'd2:    r = CH_ZERO;
                3'd3:    r = CH_ZERO;
                3'd4:    r = hex_digit(c[7:4]);
                default: r = hex_digit(c[3:0]);
            endcase
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/bue_if.sv
`timescale 1ns / 1ps

interface bue_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source(output valid, output in_byte, output last, input ready);
    modport sink(input valid, input in_byte, input last, output ready);
endinterface

interface bue_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;

    modport source(output valid, output out_byte, output byte_valid, output run_last,
                   output stream_end, input ready);
    modport sink(input valid, input out_byte, input byte_valid, input run_last,
                 input stream_end, output ready);
endinterface

FILE: rtl/core/bom_utf16le_to_escaped_utf8_core.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                                   | Transaction
// i_in    | in  | in_byte[7:0], last                        | valid && ready
// o_out   | out | out_byte[7:0], byte_valid, run_last,      | valid && ready
//         |     | stream_end                                |
//
// An accepted byte is decoded at once into at most two code points in the item register.
// The output register then takes one escaped byte per cycle while o_out is not stalled;
// the next input transaction is taken in the cycle in which the last byte of an item
// moves out, and the first result passes through the item register and then the output
// register. Reset is synchronous and active low and clears control state, not payloads.
// A stall on o_out holds the output and item registers and so holds off i_in as well.
module bom_utf16le_to_escaped_utf8_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bue_in_if.sink    i_in,
    bue_out_if.source o_out
);
    import bue_pkg::*;

    // The front end decodes an accepted byte into an item record straight away.
    t_item front_item;
    logic  in_accept;

    assign in_accept = i_in.valid && i_in.ready;

    bue_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.last),
        .o_item   (front_item)
    );

    // Item register: the code points of one input transaction under delivery.
    t_item r_item;
    logic  r_item_valid;

    // Serialiser position: code point slot, UTF-8 byte index, escape index.
    logic       r_slot;
    logic [1:0] r_bidx;
    logic [2:0] r_eidx;
    logic       r_in_string;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_bvalid;
    logic       r_out_run_last;
    logic       r_out_end;

    logic [CP_W-1:0] cur_cp;
    logic [1:0]      u8_last;
    logic [7:0]      u8_byte;
    logic [2:0]      e_last;
    logic [7:0]      e_byte;
    logic            bare;
    logic            emit;
    logic            advance;
    logic            step_ok;
    logic            last_esc;
    logic            last_u8;
    logic            last_step;
    logic            done;

    always_comb begin
        cur_cp   = r_slot ? r_item.cp1 : r_item.cp0;
        u8_last  = utf8_last(cur_cp, r_item.raw);
        u8_byte  = utf8_byte(cur_cp, u8_last, r_bidx);
        e_last   = esc_last(u8_byte, r_in_string);
        e_byte   = esc_byte(u8_byte, r_in_string, r_eidx);
        bare     = (r_item.ncp == 2'd0);
        // Empty items without the end flag pass through without output.
        emit     = r_item_valid && (!bare || r_item.fin);
        advance  = !r_out_valid || o_out.ready;
        step_ok  = r_item_valid && (!emit || advance);
        last_esc = (r_eidx == e_last);
        last_u8  = last_esc && (r_bidx == u8_last);
        last_step = bare || (last_u8 && ({1'b0, r_slot} == 2'(r_item.ncp - 2'd1)));
        done     = step_ok && last_step;
    end

    assign i_in.ready = !r_item_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_accept) begin
            r_item_valid <= 1'b1;
        end else if (done) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= front_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= 1'b0;
            r_bidx      <= 2'd0;
            r_eidx      <= 3'd0;
            r_in_string <= 1'b0;
        end else if (step_ok) begin
            if (last_step) begin
                r_slot <= 1'b0;
                r_bidx <= 2'd0;
                r_eidx <= 3'd0;
            end else if (last_u8) begin
                r_slot <= 1'b1;
                r_bidx <= 2'd0;
                r_eidx <= 3'd0;
            end else if (last_esc) begin
                r_bidx <= 2'(r_bidx + 2'd1);
                r_eidx <= 3'd0;
            end else begin
                r_eidx <= 3'(r_eidx + 3'd1);
            end
            // A quote opens a string outside one and closes it inside.
            if (last_step && r_item.fin) begin
                r_in_string <= 1'b0;
            end else if (!bare && last_esc && u8_byte == CH_QUOTE) begin
                r_in_string <= !r_in_string;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_byte     <= bare ? 8'd0 : e_byte;
            r_out_bvalid   <= !bare;
            r_out_run_last <= last_step;
            r_out_end      <= last_step && r_item.fin;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.byte_valid = r_out_bvalid;
    assign o_out.run_last   = r_out_run_last;
    assign o_out.stream_end = r_out_end;

    // A bare end marker only ever closes a document.
    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.byte_valid) |-> (o_out.run_last && o_out.stream_end))
        else $error("bare marker without end flags");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stream_end) |-> o_out.run_last)
        else $error("stream end without run end");

    // The escape state starts afresh after a document ends.
    a_string_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_item.fin) |=> !r_in_string)
        else $error("string flag survived end of document");

    a_raw_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && r_item.raw) |-> (r_item.ncp == 2'd1))
        else $error("raw item with wrong code point count");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && r_slot) |-> (r_item.ncp == 2'd2))
        else $error("serialiser beyond last code point");

endmodule

FILE: rtl/core/bue_front.sv
`timescale 1ns / 1ps

// Front end: format detection, UTF-16 unit assembly and surrogate pairing.
// Turns one input byte into up to two code points (or one raw UTF-8 byte).
module bue_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output bue_pkg::t_item o_item
);
    import bue_pkg::*;

    logic [1:0]  r_head_count, n_head_count;
    logic [15:0] r_head_bytes, n_head_bytes;
    t_mode       r_mode,       n_mode;
    logic [7:0]  r_low_byte,   n_low_byte;
    logic        r_low_held,   n_low_held;
    logic [9:0]  r_pend_high,  n_pend_high;
    logic        r_pend_valid, n_pend_valid;

    logic        unit_v;
    logic [15:0] unit;
    logic [1:0]  cnt;
    logic [7:0]  b0, b1;
    t_item       item;

    always_comb begin
        n_head_count = r_head_count;
        n_head_bytes = r_head_bytes;
        n_mode       = r_mode;
        n_low_byte   = r_low_byte;
        n_low_held   = r_low_held;
        n_pend_high  = r_pend_high;
        n_pend_valid = r_pend_valid;
        unit_v       = 1'b0;
        unit         = 16'd0;
        b0           = r_head_bytes[7:0];
        b1           = r_head_bytes[15:8];
        cnt          = (r_head_count == 2'd3) ? 2'd3 : 2'(r_head_count + 2'd1);
        item         = '0;
        item.fin     = i_last;

        unique case (r_mode)
            MODE_UNDECIDED: begin
                if (cnt == 2'd3 || i_last) begin
                    n_head_count = 2'd0;
                    n_head_bytes = 16'd0;
                    if (cnt == 2'd3 && b0 == BOM8_0 && b1 == BOM8_1 && i_byte == BOM8_2) begin
                        n_mode = MODE_UTF8;
                    end else begin
                        n_mode = MODE_UTF16;
                        if (cnt == 2'd1) begin
                            n_low_byte = i_byte;
                            n_low_held = 1'b1;
                        end else if (cnt == 2'd2) begin
                            if (!(b0 == BOM16_0 && i_byte == BOM16_1)) begin
                                unit_v = 1'b1;
                                unit   = {i_byte, b0};
                            end
                        end else begin
                            n_low_byte = i_byte;
                            n_low_held = 1'b1;
                            if (!(b0 == BOM16_0 && b1 == BOM16_1)) begin
                                unit_v = 1'b1;
                                unit   = {b1, b0};
                            end
                        end
                    end
                end else begin
                    n_head_count = cnt;
                    if (cnt == 2'd1) begin
                        n_head_bytes[7:0] = i_byte;
                    end else begin
                        n_head_bytes[15:8] = i_byte;
                    end
                end
            end
            MODE_UTF8: begin
                item.raw = 1'b1;
                item.ncp = 2'd1;
                item.cp0 = {13'd0, i_byte};
            end
            default: begin
                if (r_low_held) begin
                    n_low_held = 1'b0;
                    unit_v     = 1'b1;
                    unit       = {i_byte, r_low_byte};
                end else begin
                    n_low_byte = i_byte;
                    n_low_held = 1'b1;
                end
            end
        endcase

        // Surrogate pairing.
        if (unit_v) begin
            if (r_pend_valid && unit[15:10] == SURR_LO_TAG) begin
                item.cp0     = SUPP_BASE + {1'b0, r_pend_high, unit[9:0]};
                item.ncp     = 2'd1;
                n_pend_valid = 1'b0;
            end else begin
                if (r_pend_valid) begin
                    item.cp0     = {5'd0, SURR_HI_TAG, r_pend_high};
                    item.ncp     = 2'd1;
                    n_pend_valid = 1'b0;
                end
                if (unit[15:10] == SURR_HI_TAG) begin
                    n_pend_high  = unit[9:0];
                    n_pend_valid = 1'b1;
                end else if (item.ncp == 2'd0) begin
                    item.cp0 = {5'd0, unit};
                    item.ncp = 2'd1;
                end else begin
                    item.cp1 = {5'd0, unit};
                    item.ncp = 2'd2;
                end
            end
        end

        // A high surrogate still waiting at the end goes out on its own.
        if (i_last && n_pend_valid) begin
            if (item.ncp == 2'd0) begin
                item.cp0 = {5'd0, SURR_HI_TAG, n_pend_high};
                item.ncp = 2'd1;
            end else begin
                item.cp1 = {5'd0, SURR_HI_TAG, n_pend_high};
                item.ncp = 2'd2;
            end
        end

        if (i_last) begin
            n_head_count = 2'd0;
            n_head_bytes = 16'd0;
            n_mode       = MODE_UNDECIDED;
            n_low_byte   = 8'd0;
            n_low_held   = 1'b0;
            n_pend_high  = 10'd0;
            n_pend_valid = 1'b0;
        end
    end

    assign o_item = item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_count <= 2'd0;
            r_head_bytes <= 16'd0;
            r_mode       <= MODE_UNDECIDED;
            r_low_byte   <= 8'd0;
            r_low_held   <= 1'b0;
            r_pend_high  <= 10'd0;
            r_pend_valid <= 1'b0;
        end else if (i_accept) begin
            r_head_count <= n_head_count;
            r_head_bytes <= n_head_bytes;
            r_mode       <= n_mode;
            r_low_byte   <= n_low_byte;
            r_low_held   <= n_low_held;
            r_pend_high  <= n_pend_high;
            r_pend_valid <= n_pend_valid;
        end
    end

endmodule

FILE: test/bom_utf16le_to_escaped_utf8_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the escaping UTF-16LE / UTF-8 document transcoder.
// Documents are built up front as a queue of raw bytes. A clocked driver
// offers them on the input channel and a clocked monitor checks every output
// transaction against a queue of escaped bytes that a local transcoder model
// fills as each input transaction is accepted.
module bom_utf16le_to_escaped_utf8_core_tb;

    import bue_pkg::*;

    // One raw document byte waiting to be sent. When hold is set, the driver
    // will not offer the byte until every escaped byte already owed has arrived.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } t_doc_byte;

    // One output transaction as the block should deliver it.
    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       item_end;
        logic       doc_end;
    } t_esc_byte;

    localparam int          MAX_PER_ITEM   = 9;
    localparam int          RANDOM_ITEMS   = 250;
    localparam int          IDLE_PCT       = 25;
    // Neither side idles at random while the accepted byte count is inside this window.
    localparam int          CALM_FROM      = 100;
    localparam int          CALM_TO        = 160;
    localparam int          DRAIN_CYCLES   = 24;
    localparam int          MAX_REPORTS    = 30;
    // Even under the worst random stalls, this is many times the slowest
    // legal gap between transactions on one side or the other of a correct
    // block.
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [15:0] HI_SURR_FIRST  = 16'hD800;
    localparam logic [15:0] HI_SURR_LAST   = 16'hDBFF;
    localparam logic [15:0] LO_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LO_SURR_LAST   = 16'hDFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bue_in_if  in_if();
    bue_out_if out_if();

    bom_utf16le_to_escaped_utf8_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    t_doc_byte doc_bytes_q[$];
    t_esc_byte escaped_q[$];

    int   bytes_taken   = 0;
    int   results_seen  = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    int   utf8_docs     = 0;
    int   utf16_docs    = 0;
    int   directed_len  = 0;
    logic in_sent       = 1'b0;
    logic calm;

    assign calm = (bytes_taken >= CALM_FROM) && (bytes_taken < CALM_TO);

    // ------------------------------------------------------------------
    // Transcoder model. Its state mirrors the decoder and escape state of
    // the block; it is cleared at the end of every document.
    // ------------------------------------------------------------------
    logic [1:0]  hd_count;
    logic [15:0] hd_bytes;
    t_mode       doc_mode;
    logic [7:0]  lo_byte;
    logic        lo_held;
    logic [9:0]  hi_pend;
    logic        hi_pend_ok;
    logic        quoted;
    logic [7:0]  item_bytes[$];

    function automatic void clear_decoder();
        hd_count   = 2'd0;
        hd_bytes   = 16'd0;
        doc_mode   = MODE_UNDECIDED;
        lo_byte    = 8'd0;
        lo_held    = 1'b0;
        hi_pend    = 10'd0;
        hi_pend_ok = 1'b0;
        quoted     = 1'b0;
    endfunction

    function automatic void emit_raw(logic [7:0] b);
        if (item_bytes.size() < MAX_PER_ITEM) begin
            item_bytes = {item_bytes, b};
        end
    endfunction

    // Lower-case hex digit for the backslash-u escape.
    function automatic logic [7:0] nibble_ascii(logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h57 + 8'(v));
    endfunction

    // The escape pass: a quote toggles the string flag, and inside a string a
    // backslash is doubled and control bytes become six-byte escapes.
    function automatic void escape_byte(logic [7:0] c);
        if (!quoted) begin
            emit_raw(c);
            if (c == CH_QUOTE) begin
                quoted = 1'b1;
            end
        end else if (c == CH_QUOTE) begin
            quoted = 1'b0;
            emit_raw(c);
        end else if (c == CH_BSLASH) begin
            emit_raw(CH_BSLASH);
            emit_raw(CH_BSLASH);
        end else if (c < CH_SPACE) begin
            emit_raw(CH_BSLASH);
            emit_raw(CH_U);
            emit_raw(CH_ZERO);
            emit_raw(CH_ZERO);
            emit_raw(nibble_ascii(c[7:4]));
            emit_raw(nibble_ascii(c[3:0]));
        end else begin
            emit_raw(c);
        end
    endfunction

    function automatic void encode_cp(logic [20:0] cp);
        if (cp <= 21'h7F) begin
            escape_byte(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            escape_byte({3'b110, cp[10:6]});
            escape_byte({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            escape_byte({4'b1110, cp[15:12]});
            escape_byte({2'b10, cp[11:6]});
            escape_byte({2'b10, cp[5:0]});
        end else begin
            escape_byte({5'b11110, cp[20:18]});
            escape_byte({2'b10, cp[17:12]});
            escape_byte({2'b10, cp[11:6]});
            escape_byte({2'b10, cp[5:0]});
        end
    endfunction

    // A held high surrogate either joins a following low surrogate or is sent
    // out on its own before the new unit is handled.
    function automatic void take_unit(logic [15:0] u);
        if (hi_pend_ok) begin
            hi_pend_ok = 1'b0;
            if (u >= LO_SURR_FIRST && u <= LO_SURR_LAST) begin
                encode_cp(SUPP_BASE + {1'b0, hi_pend, u[9:0]});
                hi_pend = 10'd0;
                return;
            end
            encode_cp(21'(HI_SURR_FIRST) + 21'(hi_pend));
            hi_pend = 10'd0;
        end
        if (u >= HI_SURR_FIRST && u <= HI_SURR_LAST) begin
            hi_pend    = u[9:0];
            hi_pend_ok = 1'b1;
        end else begin
            encode_cp(21'(u));
        end
    endfunction

    function automatic void take_byte16(logic [7:0] b);
        if (!lo_held) begin
            lo_byte = b;
            lo_held = 1'b1;
        end else begin
            lo_held = 1'b0;
            take_unit({b, lo_byte});
        end
    endfunction

    // Settle the format from the buffered head bytes and the current one.
    function automatic void decide_head(logic [7:0] b, logic [1:0] count);
        logic [7:0] head[3];
        int         start;
        head[0]                = hd_bytes[7:0];
        head[1]                = hd_bytes[15:8];
        head[2]                = b;
        head[int'(count) - 1]  = b;
        start                  = 0;
        if (count == 2'd3 && head[0] == BOM8_0 && head[1] == BOM8_1 && b == BOM8_2) begin
            doc_mode = MODE_UTF8;
            utf8_docs++;
            return;
        end
        doc_mode = MODE_UTF16;
        utf16_docs++;
        if (count >= 2'd2 && head[0] == BOM16_0 && head[1] == BOM16_1) begin
            start = 2;
        end
        for (int i = start; i < int'(count); i++) begin
            take_byte16(head[i]);
        end
    endfunction

    // Work out every output transaction that one accepted input byte causes
    // and append them to the queue of escaped bytes owed by the block.
    function automatic void transcode_byte(logic [7:0] b, logic fin);
        logic [1:0] cnt;
        t_esc_byte  rec;
        int         n;
        item_bytes.delete();
        if (doc_mode == MODE_UNDECIDED) begin
            cnt = hd_count + 2'd1;
            if (cnt == 2'd3 || fin) begin
                decide_head(b, cnt);
                hd_count = 2'd0;
                hd_bytes = 16'd0;
            end else begin
                if (cnt == 2'd1) begin
                    hd_bytes[7:0] = b;
                end else begin
                    hd_bytes[15:8] = b;
                end
                hd_count = cnt;
            end
        end else if (doc_mode == MODE_UTF8) begin
            escape_byte(b);
        end else begin
            take_byte16(b);
        end
        // A high surrogate still waiting at the end of the document goes out alone.
        if (fin && doc_mode != MODE_UTF8 && hi_pend_ok) begin
            encode_cp(21'(HI_SURR_FIRST) + 21'(hi_pend));
            hi_pend_ok = 1'b0;
        end
        n = item_bytes.size();
        for (int i = 0; i < n; i++) begin
            rec.data       = item_bytes[i];
            rec.data_valid = 1'b1;
            rec.item_end   = (i == n - 1);
            rec.doc_end    = fin && (i == n - 1);
            escaped_q      = {escaped_q, rec};
        end
        // A document whose final byte yields nothing still ends with a marker.
        if (fin && n == 0) begin
            rec.data       = 8'd0;
            rec.data_valid = 1'b0;
            rec.item_end   = 1'b1;
            rec.doc_end    = 1'b1;
            escaped_q      = {escaped_q, rec};
        end
        if (fin) begin
            clear_decoder();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    task automatic add_doc(input logic [7:0] doc[$], input logic hold);
        t_doc_byte item;
        foreach (doc[i]) begin
            item.data = doc[i];
            item.last = (i == doc.size() - 1);
            item.hold = hold && (i == 0);
            doc_bytes_q = {doc_bytes_q, item};
        end
    endtask

    // Text-like byte, weighted towards the characters the escape pass cares about.
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0, 1, 2, 3: c = CH_QUOTE;
            4, 5:       c = CH_BSLASH;
            6, 7, 8:    c = 8'($urandom_range(0, 31));
            9, 10, 11, 12, 13: c = 8'($urandom_range(32, 126));
            default:    c = 8'($urandom);
        endcase
        return c;
    endfunction

    task automatic add_random_doc(input logic hold);
        logic [7:0]  body[$];
        logic [15:0] u;
        int          kind;
        int          len;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            // UTF-8 document behind its mark; the body passes unchecked.
            body = {BOM8_0, BOM8_1, BOM8_2};
            len  = $urandom_range(0, 12);
            repeat (len) begin
                body = {body, (($urandom_range(0, 4) == 0) ? 8'($urandom) : pick_text_byte())};
            end
        end else if (kind < 8) begin
            // UTF-16LE document, mostly with its mark, built from whole units and sometimes an odd byte.
            if (kind < 6) begin
                body = {BOM16_0, BOM16_1};
            end
            len = $urandom_range(0, 8);
            repeat (len) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: u = {8'd0, pick_text_byte()};
                    4:          u = 16'($urandom);
                    5, 6: begin
                        u = HI_SURR_FIRST | 16'($urandom_range(0, 1023));
                        body = {body, u[7:0], u[15:8]};
                        u = LO_SURR_FIRST | 16'($urandom_range(0, 1023));
                    end
                    7:          u = HI_SURR_FIRST | 16'($urandom_range(0, 1023));
                    8:          u = LO_SURR_FIRST | 16'($urandom_range(0, 1023));
                    default:    u = 16'($urandom_range(16'h80, 16'hFFFF));
                endcase
                body = {body, u[7:0], u[15:8]};
            end
            if ($urandom_range(0, 3) == 0) begin
                body = {body, 8'($urandom)};
            end
        end else begin
            // Short noise, rich in near misses of either mark.
            len = $urandom_range(1, 6);
            repeat (len) begin
                case ($urandom_range(0, 5))
                    0:       body = {body, BOM8_0};
                    1:       body = {body, BOM8_1};
                    2:       body = {body, BOM8_2};
                    3:       body = {body, BOM16_0};
                    4:       body = {body, BOM16_1};
                    default: body = {body, 8'($urandom)};
                endcase
            end
        end
        if (body.size() == 0) begin
            body = {body, 8'($urandom)};
        end
        add_doc(body, hold);
    endtask

    // ------------------------------------------------------------------
    // Reporting.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver. Inputs change on the falling edge. A byte that has been offered
    // stays on the channel until a transaction takes it; only then is the
    // next one (or an idle cycle) chosen.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            if (!(in_if.valid && !in_sent)) begin
                if (doc_bytes_q.size() == 0
                        || (!calm && $urandom_range(0, 99) < IDLE_PCT)
                        || (doc_bytes_q[0].hold && escaped_q.size() != 0)) begin
                    in_if.valid <= 1'b0;
                end else begin
                    in_if.valid   <= 1'b1;
                    in_if.in_byte <= doc_bytes_q[0].data;
                    in_if.last    <= doc_bytes_q[0].last;
                end
            end
            out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Both channels are sampled on the rising edge. An accepted
    // input byte is run through the model first; an accepted output byte is
    // then compared with the oldest escaped byte still owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : sample_channels
        t_esc_byte got;
        t_esc_byte want;
        if (!i_rst_n) begin
            in_sent      <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_sent <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) begin
                transcode_byte(in_if.in_byte, in_if.last);
                void'(doc_bytes_q.pop_front());
                bytes_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                got.data       = out_if.out_byte;
                got.data_valid = out_if.byte_valid;
                got.item_end   = out_if.run_last;
                got.doc_end    = out_if.stream_end;
                results_seen++;
                if (escaped_q.size() == 0) begin
                    report_mismatch($sformatf("result %02h %b%b%b with nothing expected",
                                              got.data, got.data_valid, got.item_end,
                                              got.doc_end));
                end else begin
                    want = escaped_q.pop_front();
                    if (got.data !== want.data) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  got.data, want.data));
                    end
                    if (got.data_valid !== want.data_valid) begin
                        report_mismatch($sformatf("byte_valid %b, expected %b",
                                                  got.data_valid, want.data_valid));
                    end
                    if (got.item_end !== want.item_end) begin
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  got.item_end, want.item_end));
                    end
                    if (got.doc_end !== want.doc_end) begin
                        report_mismatch($sformatf("stream_end %b, expected %b",
                                                  got.doc_end, want.doc_end));
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d results still owed",
                         quiet_cycles, escaped_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: build all documents, reset, let the driver and monitor run,
    // then drain and report.
    // ------------------------------------------------------------------
    initial begin : run_sequence
        logic [7:0] doc[$];
        int         doc_index;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.in_byte  = 8'd0;
        in_if.last     = 1'b0;
        out_if.ready   = 1'b0;
        doc_index      = 0;
        clear_decoder();

        // UTF-8 behind its mark: a quoted string holding a backslash and a
        // control byte, then a top-bit byte that passes through unchecked.
        doc = {BOM8_0, BOM8_1, BOM8_2, CH_QUOTE, CH_BSLASH, 8'h01, CH_QUOTE, 8'hFF};
        add_doc(doc, 1'b0);
        // A document that is nothing but the UTF-16 mark ends with a bare marker.
        doc = {BOM16_0, BOM16_1};
        add_doc(doc, 1'b0);
        // A single byte: too short to decide, so UTF-16, and the odd byte is dropped.
        doc = {8'h41};
        add_doc(doc, 1'b0);
        // UTF-16LE: a surrogate pair, a high surrogate followed by an ordinary
        // unit, a lone low surrogate, and a high surrogate as the final unit.
        doc = {BOM16_0, BOM16_1, 8'h3D, 8'hD8, 8'h00, 8'hDE, 8'h00, 8'hD8, 8'h41, 8'h00,
               8'h00, 8'hDC, 8'h00, 8'hDB};
        add_doc(doc, 1'b1);
        directed_len = doc_bytes_q.size();

        // Random documents; every eighth one waits for the block to empty first.
        while (doc_bytes_q.size() < directed_len + RANDOM_ITEMS) begin
            add_random_doc(doc_index % 8 == 0);
            doc_index++;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (doc_bytes_q.size() != 0 || escaped_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d directed) in %0d documents: %0d UTF-8, %0d UTF-16LE.",
                 bytes_taken, directed_len, utf8_docs + utf16_docs, utf8_docs, utf16_docs);
        $display("Checked %0d output transactions; %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
